### rtl/lcdrf_pkg.sv
// Shared types and constants for the LCD controller register file.
// Holds the address map, the access target codes and the queue entry type.
// No dependencies.
`timescale 1ns / 1ps

package lcdrf_pkg;

  // Memory sizes and index widths.
  localparam int VIDEO_DEPTH  = 8192;
  localparam int SPRITE_DEPTH = 160;
  localparam int VIDEO_AW     = $clog2(VIDEO_DEPTH);
  localparam int SPRITE_AW    = $clog2(SPRITE_DEPTH);

  // Request queue between the decoder and the execution side.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Address map.
  localparam logic [15:0] VIDEO_FIRST  = 16'h8000;
  localparam logic [15:0] VIDEO_LAST   = 16'h9FFF;
  localparam logic [15:0] VIDEO_MASK   = 16'h1FFF;
  localparam logic [15:0] SPRITE_FIRST = 16'hFE00;
  localparam logic [15:0] SPRITE_LAST  = 16'hFE9F;
  localparam logic [15:0] ADDR_LCDC    = 16'hFF40;
  localparam logic [15:0] ADDR_STAT    = 16'hFF41;
  localparam logic [15:0] ADDR_SCY     = 16'hFF42;
  localparam logic [15:0] ADDR_SCX     = 16'hFF43;
  localparam logic [15:0] ADDR_LY      = 16'hFF44;
  localparam logic [15:0] ADDR_LYC     = 16'hFF45;
  localparam logic [15:0] ADDR_DMA     = 16'hFF46;
  localparam logic [15:0] ADDR_BGP     = 16'hFF47;
  localparam logic [15:0] ADDR_OBP0    = 16'hFF48;
  localparam logic [15:0] ADDR_OBP1    = 16'hFF49;
  localparam logic [15:0] ADDR_WY      = 16'hFF4A;
  localparam logic [15:0] ADDR_WX      = 16'hFF4B;

  // Display timing thresholds and status mode codes.
  localparam logic [7:0] LINE_VBLANK = 8'd144;
  localparam logic [8:0] DOT_HBLANK  = 9'd320;
  localparam logic [1:0] MODE_HBLANK = 2'd0;
  localparam logic [1:0] MODE_VBLANK = 2'd1;
  localparam logic [1:0] MODE_DRAW   = 2'd3;

  // What a bus access reaches.
  typedef enum logic [3:0] {
    TGT_UNMAPPED,
    TGT_VIDEO,
    TGT_SPRITE,
    TGT_LCDC,
    TGT_STAT,
    TGT_SCY,
    TGT_SCX,
    TGT_LY,
    TGT_LYC,
    TGT_DMA,
    TGT_BGP,
    TGT_OBP0,
    TGT_OBP1,
    TGT_WY,
    TGT_WX
  } target_t;

  // Where the read byte of a finished request comes from.
  typedef enum logic [1:0] {
    SRC_REG,
    SRC_VIDEO,
    SRC_SPRITE
  } rd_src_t;

  // One decoded request as it waits in the queue.
  typedef struct packed {
    logic                 wr;
    target_t              target;
    logic [VIDEO_AW-1:0]  video_idx;
    logic [SPRITE_AW-1:0] sprite_idx;
    logic [7:0]           wdata;
    logic [7:0]           cur_line;
    logic [1:0]           mode;
  } req_t;

endpackage

### rtl/lcdrf_ram.sv
// Generic single-port RAM with a registered read port.
// Used for the video RAM and the sprite attribute RAM. No dependencies.
`timescale 1ns / 1ps

module lcdrf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // Write port and registered read; the read data holds until the next read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[addr];
    end
  end

endmodule

### rtl/lcdrf_front.sv
// Request decoder: takes bus accesses from the input stream and classifies them.
// Depends on lcdrf_pkg.
`timescale 1ns / 1ps

module lcdrf_front
  import lcdrf_pkg::*;
(
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,
  input  logic        in_tuser,
  input  logic        q_full,
  output logic        q_push,
  output req_t        q_item
);

  logic [15:0] addr;
  logic [7:0]  cur_line;
  logic [8:0]  cur_dot;
  logic        video_hit;
  logic        sprite_hit;

  assign addr     = in_tdata[15:0];
  assign cur_line = in_tdata[31:24];
  assign cur_dot  = in_tdata[40:32];

  // Accept whenever the queue has room.
  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full;

  // Memory windows, including the check against the implemented depth.
  assign video_hit = (addr >= VIDEO_FIRST) && (addr <= VIDEO_LAST)
                     && (32'(addr & VIDEO_MASK) < VIDEO_DEPTH);
  assign sprite_hit = (addr >= SPRITE_FIRST) && (addr <= SPRITE_LAST)
                      && (32'(addr[7:0]) < SPRITE_DEPTH);

  // Classify the address and precompute the display mode for status reads.
  always_comb begin
    q_item            = '0;
    q_item.wr         = in_tuser;
    q_item.video_idx  = VIDEO_AW'(addr & VIDEO_MASK);
    q_item.sprite_idx = SPRITE_AW'(addr[7:0]);
    q_item.wdata      = in_tdata[23:16];
    q_item.cur_line   = cur_line;
    if (cur_line >= LINE_VBLANK) begin
      q_item.mode = MODE_VBLANK;
    end else if (cur_dot >= DOT_HBLANK) begin
      q_item.mode = MODE_HBLANK;
    end else begin
      q_item.mode = MODE_DRAW;
    end
    if (video_hit) begin
      q_item.target = TGT_VIDEO;
    end else if (sprite_hit) begin
      q_item.target = TGT_SPRITE;
    end else begin
      case (addr)
        ADDR_LCDC: q_item.target = TGT_LCDC;
        ADDR_STAT: q_item.target = TGT_STAT;
        ADDR_SCY:  q_item.target = TGT_SCY;
        ADDR_SCX:  q_item.target = TGT_SCX;
        ADDR_LY:   q_item.target = TGT_LY;
        ADDR_LYC:  q_item.target = TGT_LYC;
        ADDR_DMA:  q_item.target = TGT_DMA;
        ADDR_BGP:  q_item.target = TGT_BGP;
        ADDR_OBP0: q_item.target = TGT_OBP0;
        ADDR_OBP1: q_item.target = TGT_OBP1;
        ADDR_WY:   q_item.target = TGT_WY;
        ADDR_WX:   q_item.target = TGT_WX;
        default:   q_item.target = TGT_UNMAPPED;
      endcase
    end
  end

endmodule

### rtl/lcdrf_queue.sv
// Short FIFO of decoded requests between the decoder and the execution side.
// Depends on lcdrf_pkg.
`timescale 1ns / 1ps

module lcdrf_queue
  import lcdrf_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  req_t push_item,
  output logic full,
  input  logic pop,
  output logic valid,
  output req_t head
);

  req_t              slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;

  assign full  = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign valid = (count_r != '0);
  assign head  = slot_r[rd_ptr_r];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

  // The fill count never passes the queue depth.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QCNT_W'(QUEUE_DEPTH))
    else $error("request queue count beyond depth");

endmodule

### rtl/lcdrf_back.sv
// Execution side: holds the LCD registers and both RAMs, carries out one
// request a cycle unless the output register is stalled, and keeps the
// result in an output register. Depends on lcdrf_pkg and lcdrf_ram.
`timescale 1ns / 1ps

module lcdrf_back
  import lcdrf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  input  req_t        q_item,
  output logic        q_pop,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata
);

  // LCD registers.
  logic [7:0] lcdc_r, lcdc_nxt;
  logic [3:0] irq_en_r, irq_en_nxt;
  logic [7:0] scy_r, scy_nxt;
  logic [7:0] scx_r, scx_nxt;
  logic [7:0] lyc_r, lyc_nxt;
  logic [7:0] bgp_r, bgp_nxt;
  logic [7:0] obp0_r, obp0_nxt;
  logic [7:0] obp1_r, obp1_nxt;
  logic [7:0] wy_r, wy_nxt;
  logic [7:0] wx_r, wx_nxt;

  // Output register.
  logic       out_valid_r, out_valid_nxt;
  rd_src_t    out_src_r, out_src_nxt;
  logic [7:0] out_rdata_r, out_rdata_nxt;
  logic       out_lreset_r, out_lreset_nxt;
  logic       out_dstart_r, out_dstart_nxt;
  logic [7:0] out_dpage_r, out_dpage_nxt;

  logic       video_we, video_re, sprite_we, sprite_re;
  logic [7:0] video_rdata, sprite_rdata;
  logic [7:0] status_byte;
  logic [7:0] rdata;

  // Take the next request when the output register is free or being drained.
  assign q_pop = q_valid && (!out_valid_r || out_tready);

  assign video_we  = q_pop && q_item.wr && (q_item.target == TGT_VIDEO);
  assign video_re  = q_pop && !q_item.wr && (q_item.target == TGT_VIDEO);
  assign sprite_we = q_pop && q_item.wr && (q_item.target == TGT_SPRITE);
  assign sprite_re = q_pop && !q_item.wr && (q_item.target == TGT_SPRITE);

  lcdrf_ram #(
    .WIDTH (8),
    .DEPTH (VIDEO_DEPTH)
  ) u_video_ram (
    .clk   (clk),
    .we    (video_we),
    .re    (video_re),
    .addr  (q_item.video_idx),
    .wdata (q_item.wdata),
    .rdata (video_rdata)
  );

  lcdrf_ram #(
    .WIDTH (8),
    .DEPTH (SPRITE_DEPTH)
  ) u_sprite_ram (
    .clk   (clk),
    .we    (sprite_we),
    .re    (sprite_re),
    .addr  (q_item.sprite_idx),
    .wdata (q_item.wdata),
    .rdata (sprite_rdata)
  );

  // Status byte: enables, line-equals-compare flag and the display mode.
  assign status_byte = {1'b0, irq_en_r, (q_item.cur_line == lyc_r), q_item.mode};

  // Register updates and result formation for the request being taken.
  always_comb begin
    lcdc_nxt       = lcdc_r;
    irq_en_nxt     = irq_en_r;
    scy_nxt        = scy_r;
    scx_nxt        = scx_r;
    lyc_nxt        = lyc_r;
    bgp_nxt        = bgp_r;
    obp0_nxt       = obp0_r;
    obp1_nxt       = obp1_r;
    wy_nxt         = wy_r;
    wx_nxt         = wx_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_src_nxt    = out_src_r;
    out_rdata_nxt  = out_rdata_r;
    out_lreset_nxt = out_lreset_r;
    out_dstart_nxt = out_dstart_r;
    out_dpage_nxt  = out_dpage_r;
    if (q_pop) begin
      out_valid_nxt  = 1'b1;
      out_src_nxt    = SRC_REG;
      out_rdata_nxt  = '0;
      out_lreset_nxt = 1'b0;
      out_dstart_nxt = 1'b0;
      out_dpage_nxt  = '0;
      if (q_item.wr) begin
        case (q_item.target)
          TGT_LCDC: lcdc_nxt   = q_item.wdata;
          TGT_STAT: irq_en_nxt = q_item.wdata[6:3];
          TGT_SCY:  scy_nxt    = q_item.wdata;
          TGT_SCX:  scx_nxt    = q_item.wdata;
          TGT_LY:   out_lreset_nxt = 1'b1;
          TGT_LYC:  lyc_nxt    = q_item.wdata;
          TGT_DMA: begin
            out_dstart_nxt = 1'b1;
            out_dpage_nxt  = q_item.wdata;
          end
          TGT_BGP:  bgp_nxt    = q_item.wdata;
          TGT_OBP0: obp0_nxt   = q_item.wdata;
          TGT_OBP1: obp1_nxt   = q_item.wdata;
          TGT_WY:   wy_nxt     = q_item.wdata;
          TGT_WX:   wx_nxt     = q_item.wdata;
          default: ;
        endcase
      end else begin
        case (q_item.target)
          TGT_VIDEO:  out_src_nxt   = SRC_VIDEO;
          TGT_SPRITE: out_src_nxt   = SRC_SPRITE;
          TGT_LCDC:   out_rdata_nxt = lcdc_r;
          TGT_STAT:   out_rdata_nxt = status_byte;
          TGT_SCY:    out_rdata_nxt = scy_r;
          TGT_SCX:    out_rdata_nxt = scx_r;
          TGT_LY:     out_rdata_nxt = q_item.cur_line;
          TGT_LYC:    out_rdata_nxt = lyc_r;
          TGT_BGP:    out_rdata_nxt = bgp_r;
          TGT_OBP0:   out_rdata_nxt = obp0_r;
          TGT_OBP1:   out_rdata_nxt = obp1_r;
          TGT_WY:     out_rdata_nxt = wy_r;
          TGT_WX:     out_rdata_nxt = wx_r;
          default:    out_rdata_nxt = '0;
        endcase
      end
    end
  end

  // Control state and LCD registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      lcdc_r      <= '0;
      irq_en_r    <= '0;
      scy_r       <= '0;
      scx_r       <= '0;
      lyc_r       <= '0;
      bgp_r       <= '0;
      obp0_r      <= '0;
      obp1_r      <= '0;
      wy_r        <= '0;
      wx_r        <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      lcdc_r      <= lcdc_nxt;
      irq_en_r    <= irq_en_nxt;
      scy_r       <= scy_nxt;
      scx_r       <= scx_nxt;
      lyc_r       <= lyc_nxt;
      bgp_r       <= bgp_nxt;
      obp0_r      <= obp0_nxt;
      obp1_r      <= obp1_nxt;
      wy_r        <= wy_nxt;
      wx_r        <= wx_nxt;
    end
  end

  // Result payload needs no reset.
  always_ff @(posedge clk) begin
    out_src_r    <= out_src_nxt;
    out_rdata_r  <= out_rdata_nxt;
    out_lreset_r <= out_lreset_nxt;
    out_dstart_r <= out_dstart_nxt;
    out_dpage_r  <= out_dpage_nxt;
  end

  // Memory reads take the RAM output, which holds while the result waits.
  always_comb begin
    case (out_src_r)
      SRC_VIDEO:  rdata = video_rdata;
      SRC_SPRITE: rdata = sprite_rdata;
      default:    rdata = out_rdata_r;
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0, out_dpage_r, out_dstart_r, out_lreset_r, rdata};

  // A result never carries both pulses.
  a_one_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_lreset_r && out_dstart_r))
    else $error("line reset and copy start in one result");

  // The copy page is zero unless a copy is started.
  a_page_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_dstart_r) |-> (out_dpage_r == '0))
    else $error("copy page set without copy start");

  // A line reset comes from a write, so its read byte is zero.
  a_lreset_rdata: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_lreset_r) |-> (out_src_r == SRC_REG && out_rdata_r == '0))
    else $error("line reset result carries read data");

  // A compare register write takes effect right after the request is taken.
  a_lyc_write: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && q_item.wr && q_item.target == TGT_LYC) |=> (lyc_r == $past(q_item.wdata)))
    else $error("line compare write lost");

endmodule

### rtl/lcd_controller_register_file_top.sv
// LCD controller register file, bus-side register interface.
//
// Input stream: one request per bus byte access. in_tuser is the access kind
// (1 = write, 0 = read); in_tdata carries address, write byte and the current
// line and dot from the display timing unit. Every request yields exactly one
// result on the output stream: the read byte (zero for writes and unmapped
// addresses), the line-reset pulse for a write to LY and the copy start pulse
// with its source page for a write to the DMA register.
// A result passes through the request queue and the output register before it
// appears on the output. Throughput: one request per cycle while the receiver
// is ready, set by the single port of each RAM and the one-request-per-cycle
// execution side.
// A two-entry queue parts the decoder from the execution side, and the result
// sits in an output register; while the receiver stalls, the queue fills and
// in_tready drops once it is full, with no request lost.
// Reset (rst_n low, synchronous) clears the LCD registers, the queue fill state
// and the output valid flag. Video and sprite RAM contents are undefined until written.
// Depends on lcdrf_pkg, lcdrf_front, lcdrf_queue and lcdrf_back.
`timescale 1ns / 1ps

module lcd_controller_register_file_top
  import lcdrf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // addr[15:0], wdata[23:16], cur_line[31:24], cur_dot[40:32]
  input  logic        in_tuser,   // cmd[0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // rdata[7:0], line_reset[8], dma_start[9], dma_page[17:10]
);

  logic q_full;
  logic q_push;
  logic q_pop;
  logic q_valid;
  req_t push_item;
  req_t head_item;

  // Address decode and intake.
  lcdrf_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_item    (push_item)
  );

  // Decoded request queue.
  lcdrf_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .head      (head_item)
  );

  // Register and memory access, result register.
  lcdrf_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_item     (head_item),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

### bench/tb_lcd_controller_register_file_top.sv
// Self-checking testbench for the LCD controller register file top level.
// Drives bus accesses on the input stream and checks each result against a local predictor.
// Depends on lcdrf_pkg and lcd_controller_register_file_top.
`timescale 1ns / 1ps

module tb_lcd_controller_register_file_top;
  import lcdrf_pkg::*;

  localparam bit CMD_READ      = 1'b0;
  localparam bit CMD_WRITE     = 1'b1;
  localparam int RANDOM_ITEMS  = 1024;
  localparam int STEADY_ITEMS  = 150;
  localparam int DRAIN_CYCLES  = 8;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int DIRECTED_ROWS = 26;

  // One bus access as it enters the block.
  typedef struct packed {
    logic        wr;
    logic [15:0] addr;
    logic [7:0]  wdata;
    logic [7:0]  line;
    logic [8:0]  dot;
  } bus_access_t;

  // One result as it leaves the block.
  typedef struct packed {
    logic [7:0] rdata;
    logic       line_reset;
    logic       dma_start;
    logic [7:0] dma_page;
  } access_result_t;

  // Directed row: the access and, where typed is set, the result it must give.
  typedef struct packed {
    logic        wr;
    logic [15:0] addr;
    logic [7:0]  wdata;
    logic [7:0]  line;
    logic [8:0]  dot;
    logic        typed;
    logic [7:0]  rdata;
    logic        line_reset;
    logic        dma_start;
    logic [7:0]  dma_page;
  } directed_row_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata   = '0;
  logic        in_tuser   = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;

  // Predictor copy of the register file.
  logic [7:0] video_shadow  [VIDEO_DEPTH];
  bit         video_written [VIDEO_DEPTH];
  int         video_used    [$];
  logic [7:0] sprite_shadow  [SPRITE_DEPTH];
  bit         sprite_written [SPRITE_DEPTH];
  int         sprite_used    [$];
  logic [7:0] lcdc_q, scy_q, scx_q, lyc_q, wy_q, wx_q;
  logic [3:0] irq_en_q;
  logic [7:0] palette_q [3];

  access_result_t expected_results [$];
  int  mismatch_count = 0;
  int  cycle_count    = 0;
  int  read_count     = 0;
  int  write_count    = 0;
  int  status_reads   = 0;
  int  dma_starts     = 0;
  int  line_resets    = 0;
  int  ignored_writes = 0;
  bit  steady         = 1'b0;

  directed_row_t directed_rows [DIRECTED_ROWS] = '{
    '{CMD_READ,  ADDR_LCDC, 8'h00, 8'd0,   9'd0,   1'b1, 8'h00, 1'b0, 1'b0, 8'h00},
    '{CMD_READ,  ADDR_STAT, 8'h00, 8'd0,   9'd0,   1'b1, 8'h07, 1'b0, 1'b0, 8'h00},
    '{CMD_WRITE, ADDR_LCDC, 8'hFF, 8'd0,   9'd0,   1'b1, 8'h00, 1'b0, 1'b0, 8'h00},
    '{CMD_READ,  ADDR_LCDC, 8'h00, 8'd0,   9'd0,   1'b1, 8'hFF, 1'b0, 1'b0, 8'h00},
    '{CMD_WRITE, ADDR_STAT, 8'hFF, 8'd0,   9'd0,   1'b1, 8'h00, 1'b0, 1'b0, 8'h00},
    '{CMD_READ,  ADDR_STAT, 8'h00, 8'd144, 9'd0,   1'b1, 8'h79, 1'b0, 1'b0, 8'h00},
    '{CMD_READ,  ADDR_STAT, 8'h00, 8'd143, 9'd320, 1'b1, 8'h78, 1'b0, 1'b0, 8'h00},
    '{CMD_READ,  ADDR_STAT, 8'h00, 8'd143, 9'd319, 1'b1, 8'h7B, 1'b0, 1'b0, 8'h00},
    '{CMD_WRITE, ADDR_LY,   8'h5A, 8'd0,   9'd0,   1'b1, 8'h00, 1'b1, 1'b0, 8'h00},
    '{CMD_READ,  ADDR_LY,   8'h00, 8'd255, 9'd0,   1'b1, 8'hFF, 1'b0, 1'b0, 8'h00},
    '{CMD_WRITE, ADDR_LYC,  8'hFF, 8'd0,   9'd0,   1'b1, 8'h00, 1'b0, 1'b0, 8'h00},
    '{CMD_READ,  ADDR_STAT, 8'h00, 8'd255, 9'd511, 1'b1, 8'h7D, 1'b0, 1'b0, 8'h00},
    '{CMD_WRITE, ADDR_STAT, 8'h87, 8'd0,   9'd0,   1'b1, 8'h00, 1'b0, 1'b0, 8'h00},
    '{CMD_READ,  ADDR_STAT, 8'h00, 8'd0,   9'd0,   1'b1, 8'h03, 1'b0, 1'b0, 8'h00},
    '{CMD_WRITE, ADDR_DMA,  8'hC3, 8'd0,   9'd0,   1'b1, 8'h00, 1'b0, 1'b1, 8'hC3},
    '{CMD_READ,  ADDR_DMA,  8'h00, 8'd0,   9'd0,   1'b1, 8'h00, 1'b0, 1'b0, 8'h00},
    '{CMD_WRITE, 16'h8000,  8'hFF, 8'd0,   9'd0,   1'b1, 8'h00, 1'b0, 1'b0, 8'h00},
    '{CMD_READ,  16'h8000,  8'h00, 8'd0,   9'd0,   1'b1, 8'hFF, 1'b0, 1'b0, 8'h00},
    '{CMD_WRITE, 16'h9FFF,  8'h00, 8'd0,   9'd0,   1'b1, 8'h00, 1'b0, 1'b0, 8'h00},
    '{CMD_READ,  16'h9FFF,  8'hFF, 8'd0,   9'd0,   1'b1, 8'h00, 1'b0, 1'b0, 8'h00},
    '{CMD_WRITE, 16'hFE00,  8'hA5, 8'd0,   9'd0,   1'b1, 8'h00, 1'b0, 1'b0, 8'h00},
    '{CMD_READ,  16'hFE00,  8'h00, 8'd0,   9'd0,   1'b1, 8'hA5, 1'b0, 1'b0, 8'h00},
    '{CMD_WRITE, 16'hFE9F,  8'h5A, 8'd77,  9'd100, 1'b0, 8'h00, 1'b0, 1'b0, 8'h00},
    '{CMD_READ,  16'hFE9F,  8'h00, 8'd200, 9'd400, 1'b0, 8'h00, 1'b0, 1'b0, 8'h00},
    '{CMD_WRITE, 16'hFFFF,  8'h12, 8'd0,   9'd0,   1'b1, 8'h00, 1'b0, 1'b0, 8'h00},
    '{CMD_READ,  16'hFEA0,  8'h00, 8'd0,   9'd0,   1'b1, 8'h00, 1'b0, 1'b0, 8'h00}
  };

  lcd_controller_register_file_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // Free-running clock, 8 ns period.
  initial begin
    forever #4 clk = ~clk;
  end

  // Applies one access to the shadow state and returns the result it should produce.
  function automatic access_result_t predict_access(bus_access_t a);
    access_result_t r;
    logic [1:0]     mode;
    int             idx;
    r = '0;
    if (a.addr >= VIDEO_FIRST && a.addr <= VIDEO_LAST) begin
      idx = int'(a.addr & VIDEO_MASK);
      if (a.wr) begin
        if (!video_written[idx]) video_used.push_back(idx);
        video_written[idx] = 1'b1;
        video_shadow[idx]  = a.wdata;
      end else begin
        r.rdata = video_shadow[idx];
      end
    end else if (a.addr >= SPRITE_FIRST && a.addr <= SPRITE_LAST) begin
      idx = int'(a.addr[7:0]);
      if (a.wr) begin
        if (!sprite_written[idx]) sprite_used.push_back(idx);
        sprite_written[idx] = 1'b1;
        sprite_shadow[idx]  = a.wdata;
      end else begin
        r.rdata = sprite_shadow[idx];
      end
    end else if (a.wr) begin
      case (a.addr)
        ADDR_LCDC: lcdc_q = a.wdata;
        ADDR_STAT: irq_en_q = a.wdata[6:3];
        ADDR_SCY:  scy_q = a.wdata;
        ADDR_SCX:  scx_q = a.wdata;
        ADDR_LY:   r.line_reset = 1'b1;
        ADDR_LYC:  lyc_q = a.wdata;
        ADDR_DMA: begin
          r.dma_start = 1'b1;
          r.dma_page  = a.wdata;
        end
        ADDR_BGP:  palette_q[0] = a.wdata;
        ADDR_OBP0: palette_q[1] = a.wdata;
        ADDR_OBP1: palette_q[2] = a.wdata;
        ADDR_WY:   wy_q = a.wdata;
        ADDR_WX:   wx_q = a.wdata;
        default: ;
      endcase
    end else begin
      case (a.addr)
        ADDR_LCDC: r.rdata = lcdc_q;
        ADDR_STAT: begin
          // Vertical blank wins over horizontal blank; otherwise the line is drawing.
          if (a.line >= LINE_VBLANK) mode = MODE_VBLANK;
          else if (a.dot >= DOT_HBLANK) mode = MODE_HBLANK;
          else mode = MODE_DRAW;
          r.rdata = {1'b0, irq_en_q, a.line == lyc_q, mode};
        end
        ADDR_SCY:  r.rdata = scy_q;
        ADDR_SCX:  r.rdata = scx_q;
        ADDR_LY:   r.rdata = a.line;
        ADDR_LYC:  r.rdata = lyc_q;
        ADDR_BGP:  r.rdata = palette_q[0];
        ADDR_OBP0: r.rdata = palette_q[1];
        ADDR_OBP1: r.rdata = palette_q[2];
        ADDR_WY:   r.rdata = wy_q;
        ADDR_WX:   r.rdata = wx_q;
        default: ;
      endcase
    end
    return r;
  endfunction

  // Builds a random access; most hit registers or memory that was written before.
  function automatic bus_access_t random_access(output bit ignored);
    bus_access_t a;
    int          kind;
    bit          in_video, in_sprite, in_regs;
    kind    = $urandom_range(0, 99);
    a.wr    = 1'($urandom_range(0, 1));
    a.wdata = 8'($urandom);
    // Steer the timing inputs toward the compare match and the mode edges.
    case ($urandom_range(0, 3))
      0:       a.line = lyc_q;
      1:       a.line = 8'(LINE_VBLANK - 8'd1 + 8'($urandom_range(0, 1)));
      default: a.line = 8'($urandom);
    endcase
    if ($urandom_range(0, 3) == 0) a.dot = 9'(DOT_HBLANK - 9'd1 + 9'($urandom_range(0, 1)));
    else a.dot = 9'($urandom_range(0, 511));
    if (kind < 35) begin
      if ($urandom_range(0, 15) == 0) a.addr = $urandom_range(0, 1) ? 16'hFF3F : 16'hFF4C;
      else a.addr = ADDR_LCDC + 16'($urandom_range(0, 11));
    end else if (kind < 60) begin
      if (video_used.size() == 0) a.wr = CMD_WRITE;
      if (a.wr) a.addr = VIDEO_FIRST | 16'($urandom_range(0, VIDEO_DEPTH - 1));
      else a.addr = VIDEO_FIRST | 16'(video_used[$urandom_range(0, video_used.size() - 1)]);
    end else if (kind < 80) begin
      if (sprite_used.size() == 0) a.wr = CMD_WRITE;
      if (a.wr) a.addr = SPRITE_FIRST | 16'($urandom_range(0, SPRITE_DEPTH - 1));
      else a.addr = SPRITE_FIRST | 16'(sprite_used[$urandom_range(0, sprite_used.size() - 1)]);
    end else begin
      a.addr = 16'($urandom);
    end
    in_video  = a.addr >= VIDEO_FIRST && a.addr <= VIDEO_LAST;
    in_sprite = a.addr >= SPRITE_FIRST && a.addr <= SPRITE_LAST;
    in_regs   = a.addr >= ADDR_LCDC && a.addr <= ADDR_WX;
    // A read of a memory entry that was never written turns into a write.
    if (!a.wr && in_video && !video_written[int'(a.addr & VIDEO_MASK)]) a.wr = CMD_WRITE;
    if (!a.wr && in_sprite && !sprite_written[int'(a.addr[7:0])]) a.wr = CMD_WRITE;
    ignored = a.wr && !in_video && !in_sprite && !in_regs;
    return a;
  endfunction

  // Presents one request, waits for it to be taken and records what it should return.
  task automatic issue_access(input bus_access_t a, input bit typed, input access_result_t fixed);
    access_result_t predicted;
    in_tvalid <= 1'b1;
    in_tuser  <= a.wr;
    in_tdata  <= {7'd0, a.dot, a.line, a.wdata, a.addr};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predicted = predict_access(a);
    expected_results.push_back(typed ? fixed : predicted);
    if (a.wr) write_count++;
    else read_count++;
    if (!a.wr && a.addr == ADDR_STAT) status_reads++;
    if (predicted.dma_start) dma_starts++;
    if (predicted.line_reset) line_resets++;
    // Random gap on the sending side.
    if (!steady && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  // Receiver: mostly ready, with random stall bursts until the closing stretch.
  initial begin
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (!steady && $urandom_range(0, 6) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Compares every accepted result with the oldest outstanding expectation.
  always @(posedge clk) begin : check_results
    access_result_t want;
    access_result_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got = '{rdata: out_tdata[7:0], line_reset: out_tdata[8], dma_start: out_tdata[9],
              dma_page: out_tdata[17:10]};
      if (expected_results.size() == 0) begin
        $error("unexpected result rdata=%02h line_reset=%0d dma_start=%0d dma_page=%02h",
               got.rdata, got.line_reset, got.dma_start, got.dma_page);
        mismatch_count++;
      end else begin
        want = expected_results.pop_front();
        if (got.rdata !== want.rdata) begin
          $error("rdata: expected %02h, got %02h", want.rdata, got.rdata);
          mismatch_count++;
        end
        if (got.line_reset !== want.line_reset) begin
          $error("line_reset: expected %0d, got %0d", want.line_reset, got.line_reset);
          mismatch_count++;
        end
        if (got.dma_start !== want.dma_start) begin
          $error("dma_start: expected %0d, got %0d", want.dma_start, got.dma_start);
          mismatch_count++;
        end
        if (got.dma_page !== want.dma_page) begin
          $error("dma_page: expected %02h, got %02h", want.dma_page, got.dma_page);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycle_count,
               expected_results.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Main sequence: reset, directed table, random traffic, drain.
  initial begin : run_sequence
    bus_access_t    a;
    access_result_t fixed;
    directed_row_t  row;
    bit             ignored;
    int             counted;
    lcdc_q    = '0;
    irq_en_q  = '0;
    scy_q     = '0;
    scx_q     = '0;
    lyc_q     = '0;
    wy_q      = '0;
    wx_q      = '0;
    palette_q = '{default: '0};
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      row   = directed_rows[i];
      a     = '{wr: row.wr, addr: row.addr, wdata: row.wdata, line: row.line, dot: row.dot};
      fixed = '{rdata: row.rdata, line_reset: row.line_reset, dma_start: row.dma_start,
                dma_page: row.dma_page};
      issue_access(a, row.typed, fixed);
    end

    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      steady = counted >= RANDOM_ITEMS - STEADY_ITEMS;
      a = random_access(ignored);
      issue_access(a, 1'b0, '0);
      if (ignored) ignored_writes++;
      counted++;
    end
    in_tvalid <= 1'b0;

    // Let every outstanding result come back, then wait out the drain stretch.
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d reads and %0d writes, %0d of them status reads, %0d writes unmapped",
             read_count, write_count, status_reads, ignored_writes);
    $display("Saw %0d copy starts and %0d line resets, %0d video and %0d sprite entries used",
             dma_starts, line_resets, video_used.size(), sprite_used.size());
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
